// ===== design/tpdt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the edge function for the triangle pixel depth test.
// No dependencies; imported by the top level and its checker.
package tpdt_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int COORD_W = 8;
    localparam int DEPTH_W = 16;
    localparam int CFG_W   = 9;
    localparam int EDGE_W  = 19;   // signed edge function / twice the area
    localparam int PROD_W  = EDGE_W + DEPTH_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int REM_W   = SUM_W - 1;
    localparam int AREA_W  = EDGE_W - 1;
    localparam int QUO_W   = 16;   // quotient magnitude reaches 32768 for a depth of -32768

    localparam logic signed [DEPTH_W-1:0] DEPTH_FAR = 16'sh7FFF;

    localparam logic FUNC_TEST  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               on_screen;
    } tag_t;

    // (py - y0) * (x1 - x0) - (px - x0) * (y1 - y0)
    function automatic logic signed [EDGE_W-1:0] edge_fn(
        input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
        input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1,
        input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        logic signed [COORD_W:0]     dpy, dx1, dpx, dy1;
        logic signed [2*COORD_W+1:0] p0, p1;
        dpy = $signed({1'b0, py}) - $signed({1'b0, y0});
        dx1 = $signed({1'b0, x1}) - $signed({1'b0, x0});
        dpx = $signed({1'b0, px}) - $signed({1'b0, x0});
        dy1 = $signed({1'b0, y1}) - $signed({1'b0, y0});
        p0 = dpy * dx1;
        p1 = dpx * dy1;
        return EDGE_W'(p0) - EDGE_W'(p1);
    endfunction

endpackage

// ===== design/triangle_pixel_depth_test.sv =====
`timescale 1ns / 1ps
// Triangle pixel depth test: edge functions, depth interpolation with a pipelined
// divider, and a depth store with read-modify-write forwarding. Uses tpdt_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one candidate pixel per transfer:
//   func selects a triangle test or a clear of the pixel's depth entry.
//   Output channel (out_valid/out_ready) returns exactly one result per input,
//   in order: write_pixel, the pixel coordinates and the depth now stored (0 off screen).
//   Config channel (cfg_valid/cfg_ready) writes screen_width (index 0) and
//   screen_height (index 1); cfg_ready is always high. Write only while idle.
// Timing:
//   One item per cycle sustained while out_ready stays high. Each item passes edge
//   functions, products, sum, 16 one-bit divider steps, depth finish, then store
//   read and compare. The single store port pair (one read, one write each cycle)
//   sets the rate; a same-pixel item right behind another takes its old depth
//   forwarded from the output register.
// Reset:
//   Clears all stage valid bits and loads both screen registers with 256.
//   The depth store is not cleared: issue a clear for each pixel before testing.
// Stall:
//   While a result waits with out_ready low, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated. Bubbles never stall input.
module triangle_pixel_depth_test
    import tpdt_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      func,
    input  logic [COORD_W-1:0]        pixel_x,
    input  logic [COORD_W-1:0]        pixel_y,
    input  logic [COORD_W-1:0]        vertex_a_x,
    input  logic [COORD_W-1:0]        vertex_a_y,
    input  logic [COORD_W-1:0]        vertex_b_x,
    input  logic [COORD_W-1:0]        vertex_b_y,
    input  logic [COORD_W-1:0]        vertex_c_x,
    input  logic [COORD_W-1:0]        vertex_c_y,
    input  logic signed [DEPTH_W-1:0] vertex_a_depth,
    input  logic signed [DEPTH_W-1:0] vertex_b_depth,
    input  logic signed [DEPTH_W-1:0] vertex_c_depth,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      write_pixel,
    output logic [COORD_W-1:0]        out_x,
    output logic [COORD_W-1:0]        out_y,
    output logic signed [DEPTH_W-1:0] out_depth
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] screen_width_reg, screen_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= CFG_W'(256);
            screen_height_reg <= CFG_W'(256);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Global advance: every stage moves when the output slot is free or drains.
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: edge functions ----------------
    logic                      s1_valid_reg;
    tag_t                      s1_tag_reg;
    logic signed [EDGE_W-1:0]  s1_w0_reg, s1_w1_reg, s1_w2_reg, s1_area_reg;
    logic signed [DEPTH_W-1:0] s1_za_reg, s1_zb_reg, s1_zc_reg;
    tag_t                      s1_tag_next;

    always_comb
    begin
        s1_tag_next.func      = func;
        s1_tag_next.x         = pixel_x;
        s1_tag_next.y         = pixel_y;
        s1_tag_next.on_screen = ({1'b0, pixel_x} < screen_width_reg) &&
                                (32'(pixel_x) < MAX_WIDTH) &&
                                ({1'b0, pixel_y} < screen_height_reg) &&
                                (32'(pixel_y) < MAX_HEIGHT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_tag_reg  <= s1_tag_next;
            s1_area_reg <= edge_fn(vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                                   vertex_c_x, vertex_c_y);
            s1_w0_reg   <= edge_fn(vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
                                   pixel_x, pixel_y);
            s1_w1_reg   <= edge_fn(vertex_c_x, vertex_c_y, vertex_a_x, vertex_a_y,
                                   pixel_x, pixel_y);
            s1_w2_reg   <= edge_fn(vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                                   pixel_x, pixel_y);
            s1_za_reg   <= vertex_a_depth;
            s1_zb_reg   <= vertex_b_depth;
            s1_zc_reg   <= vertex_c_depth;
        end
    end

    // ---------------- stage 2: weighted products ----------------
    logic                      s2_valid_reg;
    tag_t                      s2_tag_reg;
    logic                      s2_inside_reg;
    logic [AREA_W-1:0]         s2_area_reg;
    logic signed [PROD_W-1:0]  s2_p0_reg, s2_p1_reg, s2_p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_tag_reg    <= s1_tag_reg;
            // All weights non-negative and nonzero area implies a positive area.
            s2_inside_reg <= !s1_w0_reg[EDGE_W-1] && !s1_w1_reg[EDGE_W-1] &&
                             !s1_w2_reg[EDGE_W-1] && (s1_area_reg != '0);
            s2_area_reg   <= AREA_W'(s1_area_reg);
            s2_p0_reg     <= PROD_W'(s1_w0_reg * s1_za_reg);
            s2_p1_reg     <= PROD_W'(s1_w1_reg * s1_zb_reg);
            s2_p2_reg     <= PROD_W'(s1_w2_reg * s1_zc_reg);
        end
    end

    // ---------------- stage 3: sum and magnitude ----------------
    logic signed [SUM_W-1:0] s2_sum;
    assign s2_sum = SUM_W'(s2_p0_reg) + SUM_W'(s2_p1_reg) + SUM_W'(s2_p2_reg);

    logic              dv_valid_reg [0:QUO_W];
    tag_t              dv_tag_reg   [0:QUO_W];
    logic              dv_inside_reg[0:QUO_W];
    logic              dv_neg_reg   [0:QUO_W];
    logic [AREA_W-1:0] dv_area_reg  [0:QUO_W];
    logic [REM_W-1:0]  dv_rem_reg   [0:QUO_W];
    logic [QUO_W-1:0]  dv_quo_reg   [0:QUO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (en)
            dv_valid_reg[0] <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_tag_reg[0]    <= s2_tag_reg;
            dv_inside_reg[0] <= s2_inside_reg;
            dv_neg_reg[0]    <= s2_sum[SUM_W-1];
            dv_area_reg[0]   <= s2_area_reg;
            dv_rem_reg[0]    <= s2_sum[SUM_W-1] ? REM_W'(-s2_sum) : REM_W'(s2_sum);
            dv_quo_reg[0]    <= '0;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        localparam int SH = QUO_W - 1 - k;
        logic [REM_W-1:0] trial;
        logic             take;

        assign trial = REM_W'(dv_area_reg[k]) << SH;
        assign take  = dv_rem_reg[k] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (en)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_tag_reg[k+1]    <= dv_tag_reg[k];
                dv_inside_reg[k+1] <= dv_inside_reg[k];
                dv_neg_reg[k+1]    <= dv_neg_reg[k];
                dv_area_reg[k+1]   <= dv_area_reg[k];
                dv_rem_reg[k+1]    <= take ? (dv_rem_reg[k] - trial) : dv_rem_reg[k];
                dv_quo_reg[k+1]    <= dv_quo_reg[k] | (QUO_W'(take) << SH);
            end
        end
    end

    // ---------------- depth finish and store read ----------------
    logic                      p_valid_reg;
    tag_t                      p_tag_reg;
    logic                      p_inside_reg;
    logic signed [DEPTH_W-1:0] p_z_reg;
    logic [DEPTH_W-1:0]        quo_ext;

    assign quo_ext = DEPTH_W'(dv_quo_reg[QUO_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= dv_valid_reg[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_tag_reg    <= dv_tag_reg[QUO_W];
            p_inside_reg <= dv_inside_reg[QUO_W];
            // Truncation toward zero: negate the magnitude quotient.
            p_z_reg      <= dv_neg_reg[QUO_W] ? -$signed(quo_ext) : $signed(quo_ext);
        end
    end

    function automatic logic [AW-1:0] pix_addr(input tag_t t);
        return AW'(AW'(t.y) * AW'(MAX_WIDTH) + AW'(t.x));
    endfunction

    logic signed [DEPTH_W-1:0] mem [0:DEPTH-1];

    logic                      q_valid_reg;
    tag_t                      q_tag_reg;
    logic                      q_inside_reg;
    logic signed [DEPTH_W-1:0] q_z_reg;
    logic signed [DEPTH_W-1:0] q_rd_reg;
    logic [AW-1:0]             q_addr;

    assign q_addr = pix_addr(q_tag_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (en)
            q_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_tag_reg    <= p_tag_reg;
            q_inside_reg <= p_inside_reg;
            q_z_reg      <= p_z_reg;
        end
    end

    // ---------------- compare, write back, output register ----------------
    logic                      out_on_reg;
    logic [AW-1:0]             out_addr_reg;
    logic signed [DEPTH_W-1:0] old_depth;
    logic                      wr_next;
    logic signed [DEPTH_W-1:0] depth_next;

    // The item just ahead wrote at the same edge this one read: take its depth.
    assign old_depth = (out_valid && out_on_reg && (out_addr_reg == q_addr)) ?
                       out_depth : q_rd_reg;

    always_comb
    begin
        wr_next    = 1'b0;
        depth_next = old_depth;
        if (!q_tag_reg.on_screen)
        begin
            depth_next = '0;
        end
        else if (q_tag_reg.func == FUNC_CLEAR)
        begin
            wr_next    = 1'b1;
            depth_next = DEPTH_FAR;
        end
        else if (q_inside_reg && (q_z_reg < old_depth))
        begin
            wr_next    = 1'b1;
            depth_next = q_z_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_rd_reg <= mem[pix_addr(p_tag_reg)];
            if (q_valid_reg && wr_next)
                mem[q_addr] <= depth_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= q_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            write_pixel  <= wr_next;
            out_x        <= q_tag_reg.x;
            out_y        <= q_tag_reg.y;
            out_depth    <= depth_next;
            out_on_reg   <= q_tag_reg.on_screen;
            out_addr_reg <= q_addr;
        end
    end

endmodule

// ===== design/tpdt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for triangle_pixel_depth_test and its bind statement.
// Depends on tpdt_pkg and the top level's port list.
module tpdt_checker
    import tpdt_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      write_pixel,
    input logic [COORD_W-1:0]        out_x,
    input logic [COORD_W-1:0]        out_y,
    input logic signed [DEPTH_W-1:0] out_depth
);

    // Hold a stalled result unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(write_pixel) &&
        $stable(out_x) && $stable(out_y) && $stable(out_depth))
        else $error("stalled result changed");

    // Accept input whenever the output slot is empty.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Block input while a result is stalled.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during output stall");

    // Come out of reset with no result.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind triangle_pixel_depth_test tpdt_checker u_tpdt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .write_pixel (write_pixel),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_depth   (out_depth)
);
